### rtl/hcsa_pkg.sv
`default_nettype none

package hcsa_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_NUM,
    S_MUL_EA,
    S_MUL_EB,
    S_DEN,
    S_CHECK,
    S_DIV,
    S_ACC
  } state_t;

  localparam int VALUE_WIDTH = 31;
  localparam int ERROR_WIDTH = 31;
  localparam int MAG_WIDTH   = 32;
  localparam int SQ_WIDTH    = 63;
  localparam int SUM_WIDTH   = 64;

endpackage

`default_nettype wire

### rtl/histogram_chi_square_accumulator_top.sv
// Steps per item: three squares on one shared multiplier, the denominator sum, a check,
// the divider (skipped when both errors are zero or the term overflows) and accumulation;
// a last bin's result waits while out_stall holds it. No new item is taken until the
// previous one is through. The radix-2 divider forms one quotient bit per cycle.
// Reset: rst is synchronous, active high; clears the sequencer, the running sum,
// both flags and the output valid.
`default_nettype none

module histogram_chi_square_accumulator_top #(
  parameter int FRACTION_BITS = 16,
  parameter int TERM_WIDTH    = 48
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [hcsa_pkg::VALUE_WIDTH-1:0] value_a,
  input  wire logic signed [hcsa_pkg::VALUE_WIDTH-1:0] value_b,
  input  wire logic [hcsa_pkg::ERROR_WIDTH-1:0]     error_a,
  input  wire logic [hcsa_pkg::ERROR_WIDTH-1:0]     error_b,
  input  wire logic                                 last_bin,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [hcsa_pkg::SUM_WIDTH-1:0]            chi_square_sum,
  output logic                                      zero_error_seen,
  output logic                                      saturated
);

  localparam int CW = hcsa_pkg::SQ_WIDTH + TERM_WIDTH;
  localparam int CNT_WIDTH = (TERM_WIDTH > 1) ? $clog2(TERM_WIDTH) : 1;
  localparam int MW = hcsa_pkg::MAG_WIDTH;
  localparam int SW = hcsa_pkg::SQ_WIDTH;

  hcsa_pkg::state_t state, state_next;

  logic [MW-1:0]          mag;
  logic [MW-1:0]          err_a;
  logic [MW-1:0]          err_b;
  logic                   last;
  logic [2*MW-1:0]        prod;
  logic [SW-1:0]          num;
  logic [SW-1:0]          den;
  logic [SW-1:0]          rem;
  logic [TERM_WIDTH-1:0]  lo;
  logic [TERM_WIDTH-1:0]  q;
  logic [CNT_WIDTH-1:0]   count;
  logic [hcsa_pkg::SUM_WIDTH-1:0] running_sum;
  logic                   zero_error_flag;
  logic                   saturation_flag;

  logic [MW-1:0]          mul_x;
  logic                   in_take;
  logic                   out_free;

  logic signed [MW-1:0]   diff;
  logic [CW-1:0]          num_w;
  logic [CW-1:0]          den_w;
  logic                   over;
  logic [SW:0]            trial;
  logic                   fits;
  logic [SW:0]            trial_sub;
  logic [hcsa_pkg::SUM_WIDTH:0] sum_ext;

  assign diff    = MW'(value_a) - MW'(value_b);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign num_w = CW'(num) << FRACTION_BITS;
  assign den_w = CW'(den) << TERM_WIDTH;
  assign over  = (num_w >= den_w);

  assign trial     = {rem, lo[TERM_WIDTH-1]};
  assign fits      = (trial >= {1'b0, den});
  assign trial_sub = trial - {1'b0, den};

  assign sum_ext = {1'b0, running_sum} + (hcsa_pkg::SUM_WIDTH + 1)'(q);

  always_comb begin
    state_next = state;
    unique case (state)
      hcsa_pkg::S_IDLE:    if (in_take) state_next = hcsa_pkg::S_MUL_NUM;
      hcsa_pkg::S_MUL_NUM: state_next = hcsa_pkg::S_MUL_EA;
      hcsa_pkg::S_MUL_EA:  state_next = hcsa_pkg::S_MUL_EB;
      hcsa_pkg::S_MUL_EB:  state_next = hcsa_pkg::S_DEN;
      hcsa_pkg::S_DEN:     state_next = hcsa_pkg::S_CHECK;
      hcsa_pkg::S_CHECK: begin
        if (den == '0 || over) state_next = hcsa_pkg::S_ACC;
        else state_next = hcsa_pkg::S_DIV;
      end
      hcsa_pkg::S_DIV:     if (count == '0) state_next = hcsa_pkg::S_ACC;
      hcsa_pkg::S_ACC:     if (!last || out_free) state_next = hcsa_pkg::S_IDLE;
      default:             state_next = hcsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = rst || (state != hcsa_pkg::S_IDLE);
    unique case (state)
      hcsa_pkg::S_MUL_NUM: mul_x = mag;
      hcsa_pkg::S_MUL_EA:  mul_x = err_a;
      hcsa_pkg::S_MUL_EB:  mul_x = err_b;
      default:             mul_x = mag;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_x;
    unique case (state)
      hcsa_pkg::S_IDLE: begin
        mag   <= diff[MW-1] ? (-diff) : diff;
        err_a <= MW'(error_a);
        err_b <= MW'(error_b);
        last  <= last_bin;
      end
      hcsa_pkg::S_MUL_EA: num <= prod[SW-1:0];
      hcsa_pkg::S_MUL_EB: den <= prod[SW-1:0];
      hcsa_pkg::S_DEN:    den <= den + prod[SW-1:0];
      hcsa_pkg::S_CHECK: begin
        rem   <= num_w[CW-1:TERM_WIDTH];
        lo    <= num_w[TERM_WIDTH-1:0];
        count <= CNT_WIDTH'(TERM_WIDTH - 1);
        if (den == '0) q <= '0;
        else if (over) q <= '1;
        else q <= '0;
      end
      hcsa_pkg::S_DIV: begin
        rem   <= fits ? trial_sub[SW-1:0] : trial[SW-1:0];
        lo    <= lo << 1;
        q     <= {q[TERM_WIDTH-2:0], fits};
        count <= count - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      zero_error_flag <= 1'b0;
      saturation_flag <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state == hcsa_pkg::S_ACC && last)) out_valid <= 1'b0;
      if (state == hcsa_pkg::S_CHECK) begin
        if (den == '0) zero_error_flag <= 1'b1;
        else if (over) saturation_flag <= 1'b1;
      end
      if (state == hcsa_pkg::S_ACC) begin
        if (!last) begin
          running_sum <= sum_ext[hcsa_pkg::SUM_WIDTH] ? '1
                                                      : sum_ext[hcsa_pkg::SUM_WIDTH-1:0];
          if (sum_ext[hcsa_pkg::SUM_WIDTH]) saturation_flag <= 1'b1;
        end else if (out_free) begin
          chi_square_sum  <= sum_ext[hcsa_pkg::SUM_WIDTH] ? '1
                                                          : sum_ext[hcsa_pkg::SUM_WIDTH-1:0];
          zero_error_seen <= zero_error_flag;
          saturated       <= saturation_flag || sum_ext[hcsa_pkg::SUM_WIDTH];
          out_valid       <= 1'b1;
          running_sum     <= '0;
          zero_error_flag <= 1'b0;
          saturation_flag <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == hcsa_pkg::S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == hcsa_pkg::S_MUL_NUM))
    else $error("accepted item did not start the sequencer");

  a_zero_den_term: assert property (@(posedge clk) disable iff (rst)
    (state == hcsa_pkg::S_CHECK && den == '0) |=> (q == '0 && zero_error_flag))
    else $error("zero-error bin not skipped");
`endif

endmodule

`default_nettype wire
